[rtl/jvs_pkg.sv]
// jvs_pkg: widths, codes, mode coefficient tables and the step program (microcode ROM)
// for the joystick velocity shaper. No dependencies.
package jvs_pkg;

    localparam int BYTE_W     = 8;
    localparam int OFF_W      = BYTE_W + 1;
    localparam int ABS_W      = BYTE_W;
    localparam int SUM_W      = ABS_W + 1;
    localparam int DZ_W       = 7;
    localparam int LIM_W      = 14;
    localparam int VEL_W      = 15;
    localparam int VEL_EXT_W  = VEL_W + 1;
    localparam int ROT_W      = 4;
    localparam int MODE_W     = 2;
    localparam int COEF_W     = 10;
    localparam int MULT_W     = COEF_W + 1 + OFF_W;
    localparam int PROD_W     = 18;
    localparam int DVD_W      = 17;
    localparam int DVS_W      = SUM_W;
    localparam int QUO_W      = 12;
    localparam int DIV_STEPS  = QUO_W / 2;
    localparam int DCNT_W     = $clog2(DIV_STEPS);
    localparam int PC_W       = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LIM_W;

    localparam logic [DZ_W-1:0]  DZ_RESET  = DZ_W'(10);
    localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(10000);

    localparam logic [BYTE_W-1:0] STICK_CENTER = BYTE_W'(127);
    localparam logic [BYTE_W-1:0] STICK_TOP    = BYTE_W'(255);
    localparam logic [BYTE_W-1:0] STICK_BOTTOM = BYTE_W'(0);

    localparam logic [DVS_W-1:0] DIV_BY_FIVE    = DVS_W'(5);
    localparam logic [DVS_W-1:0] DIV_BY_HUNDRED = DVS_W'(100);

    localparam logic signed [VEL_EXT_W-1:0] VEL_SAT_HI = VEL_EXT_W'(2**(VEL_W-1) - 1);
    localparam logic signed [VEL_EXT_W-1:0] VEL_SAT_LO = VEL_EXT_W'(-(2**(VEL_W-1)));

    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = CFG_IDX_W'(1);

    typedef enum logic [MODE_W-1:0] {
        MODE_FAST   = 2'd0,
        MODE_MEDIUM = 2'd1,
        MODE_SLOW   = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_NOP,
        OP_MUL,
        OP_DIV,
        OP_ZERO,
        OP_SET_PROD,
        OP_SET_QUO,
        OP_RAMP_EXT,
        OP_RAMP_QUO,
        OP_ROT_ZERO,
        OP_ROT_QUO,
        OP_FINISH
    } t_op;

    typedef enum logic [1:0] {
        AX_Y,
        AX_X,
        AX_R
    } t_axis;

    typedef enum logic [1:0] {
        MS_GAIN,
        MS_GAIN3,
        MS_ACCV,
        MS_ROTK
    } t_msel;

    typedef enum logic [1:0] {
        DS_SUM,
        DS_FIVE,
        DS_HUNDRED
    } t_dsel;

    typedef enum logic [3:0] {
        JC_NEVER,
        JC_ALWAYS,
        JC_NACC,
        JC_CEN,
        JC_NORAMP,
        JC_OUTLIM,
        JC_EXT,
        JC_BUSY,
        JC_OUT_FULL
    } t_jc;

    typedef struct packed {
        t_op             op;
        t_axis           ax;
        t_msel           ms;
        t_dsel           ds;
        t_jc             jc;
        logic [PC_W-1:0] tgt;
    } t_uword;

    localparam logic [PC_W-1:0] L_IDLE       = PC_W'(0);
    localparam logic [PC_W-1:0] L_Y_WAIT     = PC_W'(7);
    localparam logic [PC_W-1:0] L_Y_RAMP_EXT = PC_W'(9);
    localparam logic [PC_W-1:0] L_Y_ZERO     = PC_W'(10);
    localparam logic [PC_W-1:0] L_Y_SET      = PC_W'(11);
    localparam logic [PC_W-1:0] L_X_START    = PC_W'(12);
    localparam logic [PC_W-1:0] L_X_WAIT     = PC_W'(18);
    localparam logic [PC_W-1:0] L_X_RAMP_EXT = PC_W'(20);
    localparam logic [PC_W-1:0] L_X_ZERO     = PC_W'(21);
    localparam logic [PC_W-1:0] L_X_DIRECT   = PC_W'(22);
    localparam logic [PC_W-1:0] L_X_WAIT5    = PC_W'(25);
    localparam logic [PC_W-1:0] L_X_SET      = PC_W'(27);
    localparam logic [PC_W-1:0] L_ROT        = PC_W'(28);
    localparam logic [PC_W-1:0] L_R_WAIT     = PC_W'(30);
    localparam logic [PC_W-1:0] L_ROT_ZERO   = PC_W'(32);
    localparam logic [PC_W-1:0] L_FIN_WAIT   = PC_W'(33);

    function automatic t_uword uw(t_op op, t_axis ax, t_msel ms, t_dsel ds, t_jc jc,
                                  logic [PC_W-1:0] tgt);
        t_uword w;
        w.op  = op;
        w.ax  = ax;
        w.ms  = ms;
        w.ds  = ds;
        w.jc  = jc;
        w.tgt = tgt;
        return w;
    endfunction

    function automatic t_uword ucode(logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            // idle
            6'd0:  w = uw(OP_ACCEPT,   AX_Y, MS_GAIN,  DS_SUM,     JC_NACC,     L_IDLE);
            // forward axis
            6'd1:  w = uw(OP_NOP,      AX_Y, MS_GAIN,  DS_SUM,     JC_CEN,      L_Y_ZERO);
            6'd2:  w = uw(OP_MUL,      AX_Y, MS_GAIN,  DS_SUM,     JC_NORAMP,   L_Y_SET);
            6'd3:  w = uw(OP_NOP,      AX_Y, MS_GAIN,  DS_SUM,     JC_OUTLIM,   L_X_START);
            6'd4:  w = uw(OP_NOP,      AX_Y, MS_GAIN,  DS_SUM,     JC_EXT,      L_Y_RAMP_EXT);
            6'd5:  w = uw(OP_MUL,      AX_Y, MS_ACCV,  DS_SUM,     JC_NEVER,    L_IDLE);
            6'd6:  w = uw(OP_DIV,      AX_Y, MS_ACCV,  DS_SUM,     JC_NEVER,    L_IDLE);
            6'd7:  w = uw(OP_NOP,      AX_Y, MS_ACCV,  DS_SUM,     JC_BUSY,     L_Y_WAIT);
            6'd8:  w = uw(OP_RAMP_QUO, AX_Y, MS_ACCV,  DS_SUM,     JC_ALWAYS,   L_X_START);
            6'd9:  w = uw(OP_RAMP_EXT, AX_Y, MS_ACCV,  DS_SUM,     JC_ALWAYS,   L_X_START);
            6'd10: w = uw(OP_ZERO,     AX_Y, MS_GAIN,  DS_SUM,     JC_ALWAYS,   L_X_START);
            6'd11: w = uw(OP_SET_PROD, AX_Y, MS_GAIN,  DS_SUM,     JC_NEVER,    L_IDLE);
            // sideways axis
            6'd12: w = uw(OP_NOP,      AX_X, MS_GAIN,  DS_SUM,     JC_CEN,      L_X_ZERO);
            6'd13: w = uw(OP_NOP,      AX_X, MS_GAIN,  DS_SUM,     JC_NORAMP,   L_X_DIRECT);
            6'd14: w = uw(OP_NOP,      AX_X, MS_GAIN,  DS_SUM,     JC_OUTLIM,   L_ROT);
            6'd15: w = uw(OP_NOP,      AX_X, MS_GAIN,  DS_SUM,     JC_EXT,      L_X_RAMP_EXT);
            6'd16: w = uw(OP_MUL,      AX_X, MS_ACCV,  DS_SUM,     JC_NEVER,    L_IDLE);
            6'd17: w = uw(OP_DIV,      AX_X, MS_ACCV,  DS_SUM,     JC_NEVER,    L_IDLE);
            6'd18: w = uw(OP_NOP,      AX_X, MS_ACCV,  DS_SUM,     JC_BUSY,     L_X_WAIT);
            6'd19: w = uw(OP_RAMP_QUO, AX_X, MS_ACCV,  DS_SUM,     JC_ALWAYS,   L_ROT);
            6'd20: w = uw(OP_RAMP_EXT, AX_X, MS_ACCV,  DS_SUM,     JC_ALWAYS,   L_ROT);
            6'd21: w = uw(OP_ZERO,     AX_X, MS_GAIN,  DS_SUM,     JC_ALWAYS,   L_ROT);
            6'd22: w = uw(OP_MUL,      AX_X, MS_GAIN,  DS_SUM,     JC_EXT,      L_X_SET);
            6'd23: w = uw(OP_MUL,      AX_X, MS_GAIN3, DS_FIVE,    JC_NEVER,    L_IDLE);
            6'd24: w = uw(OP_DIV,      AX_X, MS_GAIN3, DS_FIVE,    JC_NEVER,    L_IDLE);
            6'd25: w = uw(OP_NOP,      AX_X, MS_GAIN3, DS_FIVE,    JC_BUSY,     L_X_WAIT5);
            6'd26: w = uw(OP_SET_QUO,  AX_X, MS_GAIN3, DS_FIVE,    JC_ALWAYS,   L_ROT);
            6'd27: w = uw(OP_SET_PROD, AX_X, MS_GAIN,  DS_SUM,     JC_NEVER,    L_IDLE);
            // rotation
            6'd28: w = uw(OP_MUL,      AX_R, MS_ROTK,  DS_HUNDRED, JC_CEN,      L_ROT_ZERO);
            6'd29: w = uw(OP_DIV,      AX_R, MS_ROTK,  DS_HUNDRED, JC_NEVER,    L_IDLE);
            6'd30: w = uw(OP_NOP,      AX_R, MS_ROTK,  DS_HUNDRED, JC_BUSY,     L_R_WAIT);
            6'd31: w = uw(OP_ROT_QUO,  AX_R, MS_ROTK,  DS_HUNDRED, JC_ALWAYS,   L_FIN_WAIT);
            6'd32: w = uw(OP_ROT_ZERO, AX_R, MS_ROTK,  DS_HUNDRED, JC_NEVER,    L_IDLE);
            // result
            6'd33: w = uw(OP_NOP,      AX_Y, MS_GAIN,  DS_SUM,     JC_OUT_FULL, L_FIN_WAIT);
            6'd34: w = uw(OP_FINISH,   AX_Y, MS_GAIN,  DS_SUM,     JC_ALWAYS,   L_IDLE);
            default: w = uw(OP_NOP,    AX_Y, MS_GAIN,  DS_SUM,     JC_ALWAYS,   L_IDLE);
        endcase
        return w;
    endfunction

    function automatic logic [COEF_W-1:0] mode_gain(t_mode m);
        logic [COEF_W-1:0] v;
        unique case (m)
            MODE_FAST:   v = COEF_W'(17);
            MODE_MEDIUM: v = COEF_W'(17);
            default:     v = COEF_W'(3);
        endcase
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] mode_gain3(t_mode m);
        logic [COEF_W-1:0] v;
        unique case (m)
            MODE_FAST:   v = COEF_W'(51);
            MODE_MEDIUM: v = COEF_W'(51);
            default:     v = COEF_W'(9);
        endcase
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] mode_accv(t_mode m);
        logic [COEF_W-1:0] v;
        unique case (m)
            MODE_FAST:   v = COEF_W'(600);
            MODE_MEDIUM: v = COEF_W'(200);
            default:     v = COEF_W'(150);
        endcase
        return v;
    endfunction

    function automatic logic [COEF_W-1:0] mode_rotk(t_mode m);
        logic [COEF_W-1:0] v;
        unique case (m)
            MODE_FAST:   v = COEF_W'(3);
            MODE_MEDIUM: v = COEF_W'(4);
            default:     v = COEF_W'(1);
        endcase
        return v;
    endfunction

    function automatic logic [ABS_W-1:0] abs_off(logic signed [OFF_W-1:0] v);
        logic signed [OFF_W-1:0] n;
        n = -v;
        return v[OFF_W-1] ? n[ABS_W-1:0] : v[ABS_W-1:0];
    endfunction

endpackage

[rtl/jvs_div.sv]
// jvs_div: radix-4 restoring divider, two quotient bits per cycle, unsigned operands.
// Depends on jvs_pkg. Dividend must be below divisor times 2**QUO_W.
module jvs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [jvs_pkg::DVD_W-1:0]   i_dividend,
    input  logic [jvs_pkg::DVS_W-1:0]   i_divisor,
    output logic                        o_busy,
    output logic [jvs_pkg::QUO_W-1:0]   o_quotient
);
    import jvs_pkg::*;

    logic                r_busy, n_busy;
    logic [DCNT_W-1:0]   r_cnt, n_cnt;
    logic [DVS_W-1:0]    r_rem, n_rem;
    logic [QUO_W-1:0]    r_low, n_low;
    logic [DVS_W-1:0]    r_dvs, n_dvs;

    logic [DVS_W:0]      t1, t2, d1, d2;
    logic [DVS_W-1:0]    rem1, rem2;
    logic                q1, q2;

    always_comb begin
        t1   = {r_rem, r_low[QUO_W-1]};
        d1   = t1 - {1'b0, r_dvs};
        q1   = (t1 >= {1'b0, r_dvs});
        rem1 = q1 ? d1[DVS_W-1:0] : t1[DVS_W-1:0];
        t2   = {rem1, r_low[QUO_W-2]};
        d2   = t2 - {1'b0, r_dvs};
        q2   = (t2 >= {1'b0, r_dvs});
        rem2 = q2 ? d2[DVS_W-1:0] : t2[DVS_W-1:0];
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(DIV_STEPS - 1);
            n_rem  = DVS_W'(i_dividend[DVD_W-1:QUO_W]);
            n_low  = i_dividend[QUO_W-1:0];
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = rem2;
            n_low = {r_low[QUO_W-3:0], q1, q2};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_low <= n_low;
        r_dvs <= n_dvs;
    end

    // low on the final iteration so the step after the wait reads the result
    assign o_busy     = r_busy && (r_cnt != '0);
    assign o_quotient = r_low;

endmodule

[rtl/joystick_velocity_shaper_top.sv]
// joystick_velocity_shaper_top: turns one gamepad poll into x, y and rotation drive commands.
// Depends on jvs_pkg and jvs_div; control is a step program read from jvs_pkg::ucode.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one poll per beat: three stick bytes,
//   the ramp button and the three mode buttons. Output channel (o_out_valid/i_out_ready)
//   gives one beat per poll: x, y, rotation commands and the mode after the poll.
//   Config channel (i_cfg_valid/o_cfg_ready) is always ready; index 0 writes the dead
//   zone, index 1 the speed limit, other indexes are dropped. Write only while idle.
// Sequencing:
//   o_out_valid rises once the poll has run its path through the step program; each
//   divide on the shared divider is a start step plus wait steps until it is no longer
//   busy, and a poll needs up to three (ramp step per axis over |dx|+|dy|, x over 5,
//   rotation over 100).
//   The next poll is accepted the cycle after the result is loaded into the output
//   register; one result can wait while the next poll is in work.
// Stall: if the previous result is still unclaimed, the program holds before loading.
// Reset: mode fast, held velocities zero, dead zone 10, limit 10000, output empty.
module joystick_velocity_shaper_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [jvs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [jvs_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [jvs_pkg::BYTE_W-1:0]            i_stick_x,
    input  logic [jvs_pkg::BYTE_W-1:0]            i_stick_y,
    input  logic [jvs_pkg::BYTE_W-1:0]            i_stick_rot,
    input  logic                                  i_ramp_held,
    input  logic                                  i_pick_slow,
    input  logic                                  i_pick_medium,
    input  logic                                  i_pick_fast,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [jvs_pkg::VEL_W-1:0]      o_vel_x,
    output logic signed [jvs_pkg::VEL_W-1:0]      o_vel_y,
    output logic signed [jvs_pkg::ROT_W-1:0]      o_vel_rot,
    output logic [jvs_pkg::MODE_W-1:0]            o_mode_now
);
    import jvs_pkg::*;

    // control and architectural state
    logic [PC_W-1:0]               r_pc, n_pc;
    logic                          r_out_valid, n_out_valid;
    t_mode                         r_mode, n_mode;
    logic signed [VEL_W-1:0]       r_held_x, r_held_y;
    logic [DZ_W-1:0]               r_dead_zone;
    logic [LIM_W-1:0]              r_speed_limit;

    // payload
    logic [BYTE_W-1:0]             r_stick_x, r_stick_y, r_stick_rot;
    logic                          r_ramp, r_pick_slow, r_pick_medium, r_pick_fast;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_dsign;
    logic signed [ROT_W-1:0]       r_rot;
    logic signed [VEL_W-1:0]       r_out_x, r_out_y;
    logic signed [ROT_W-1:0]       r_out_rot;
    t_mode                         r_out_mode;

    t_uword                        cw;
    logic                          in_acc, take;
    logic signed [OFF_W-1:0]       off_x, off_y, off_r, sel_off;
    logic [ABS_W-1:0]              abs_x, abs_y, abs_r, sel_abs;
    logic [BYTE_W-1:0]             sel_byte;
    logic [SUM_W-1:0]              sum;
    logic                          sel_cen, is_ext, in_lim;
    logic signed [VEL_W-1:0]       held_sel;
    logic signed [VEL_EXT_W-1:0]   held16, lim16, step16, ramp_sum;
    logic signed [VEL_W-1:0]       ramp_new;
    logic [COEF_W-1:0]             coef, accv;
    logic signed [MULT_W-1:0]      prod_full;
    logic signed [PROD_W-1:0]      prod_neg;
    logic [DVD_W-1:0]              dvd_mag;
    logic [DVS_W-1:0]              dvs;
    logic                          div_start, div_busy;
    logic [QUO_W-1:0]              quo;
    logic signed [QUO_W:0]         q_mag, q_s, q_neg;
    logic                          held_we;
    logic signed [VEL_W-1:0]       held_val;

    assign cw          = ucode(r_pc);
    assign o_in_ready  = (cw.op == OP_ACCEPT);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign off_x = $signed({1'b0, r_stick_x})   - $signed({1'b0, STICK_CENTER});
    assign off_y = $signed({1'b0, r_stick_y})   - $signed({1'b0, STICK_CENTER});
    assign off_r = $signed({1'b0, r_stick_rot}) - $signed({1'b0, STICK_CENTER});
    assign abs_x = abs_off(off_x);
    assign abs_y = abs_off(off_y);
    assign abs_r = abs_off(off_r);
    assign sum   = {1'b0, abs_x} + {1'b0, abs_y};

    always_comb begin
        unique case (cw.ax)
            AX_X: begin
                sel_byte = r_stick_x;
                sel_off  = off_x;
                sel_abs  = abs_x;
            end
            AX_R: begin
                sel_byte = r_stick_rot;
                sel_off  = off_r;
                sel_abs  = abs_r;
            end
            default: begin
                sel_byte = r_stick_y;
                sel_off  = off_y;
                sel_abs  = abs_y;
            end
        endcase
    end

    assign held_sel = (cw.ax == AX_X) ? r_held_x : r_held_y;
    assign sel_cen  = (sel_abs <= {1'b0, r_dead_zone});
    assign is_ext   = (sel_byte == STICK_TOP) || (sel_byte == STICK_BOTTOM);
    assign held16   = VEL_EXT_W'(held_sel);
    assign lim16    = $signed({{(VEL_EXT_W-LIM_W){1'b0}}, r_speed_limit});
    assign in_lim   = (held16 < lim16) && (held16 > -lim16);

    // multiplier operand select
    assign accv = mode_accv(r_mode);
    always_comb begin
        unique case (cw.ms)
            MS_GAIN:  coef = mode_gain(r_mode);
            MS_GAIN3: coef = mode_gain3(r_mode);
            MS_ACCV:  coef = accv;
            MS_ROTK:  coef = mode_rotk(r_mode);
            default:  coef = mode_gain(r_mode);
        endcase
    end
    assign prod_full = $signed({1'b0, coef}) * sel_off;

    // divider feed: magnitude in, sign restored afterwards (truncation toward zero)
    assign prod_neg  = -r_prod;
    assign dvd_mag   = r_prod[PROD_W-1] ? prod_neg[DVD_W-1:0] : r_prod[DVD_W-1:0];
    assign div_start = (cw.op == OP_DIV);
    always_comb begin
        unique case (cw.ds)
            DS_FIVE:    dvs = DIV_BY_FIVE;
            DS_HUNDRED: dvs = DIV_BY_HUNDRED;
            default:    dvs = sum;
        endcase
    end

    jvs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd_mag),
        .i_divisor  (dvs),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    assign q_mag = $signed({1'b0, quo});
    assign q_s   = r_dsign ? -q_mag : q_mag;
    assign q_neg = -q_s;

    // ramp: y adds the step, x subtracts it; result saturates to the velocity range
    always_comb begin
        if (cw.op == OP_RAMP_EXT) begin
            step16 = $signed({{(VEL_EXT_W-COEF_W){1'b0}}, accv});
            if (sel_byte != STICK_TOP) begin
                step16 = -step16;
            end
        end else begin
            step16 = VEL_EXT_W'(q_s);
        end
        ramp_sum = (cw.ax == AX_X) ? (held16 - step16) : (held16 + step16);
        if (ramp_sum > VEL_SAT_HI) begin
            ramp_new = VEL_SAT_HI[VEL_W-1:0];
        end else if (ramp_sum < VEL_SAT_LO) begin
            ramp_new = VEL_SAT_LO[VEL_W-1:0];
        end else begin
            ramp_new = ramp_sum[VEL_W-1:0];
        end
    end

    always_comb begin
        held_we  = 1'b1;
        held_val = ramp_new;
        case (cw.op) inside
            OP_ZERO:     held_val = '0;
            OP_SET_PROD: held_val = (cw.ax == AX_X) ? prod_neg[VEL_W-1:0] : r_prod[VEL_W-1:0];
            OP_SET_QUO:  held_val = (cw.ax == AX_X) ? VEL_W'(q_neg) : VEL_W'(q_s);
            OP_RAMP_EXT, OP_RAMP_QUO: held_val = ramp_new;
            default:     held_we  = 1'b0;
        endcase
    end

    // sequencer branch
    always_comb begin
        unique case (cw.jc)
            JC_ALWAYS:   take = 1'b1;
            JC_NACC:     take = !in_acc;
            JC_CEN:      take = sel_cen;
            JC_NORAMP:   take = !r_ramp;
            JC_OUTLIM:   take = !in_lim;
            JC_EXT:      take = is_ext;
            JC_BUSY:     take = div_busy;
            JC_OUT_FULL: take = r_out_valid && !i_out_ready;
            default:     take = 1'b0;
        endcase
        n_pc = take ? cw.tgt : (r_pc + 1'b1);
    end

    always_comb begin
        n_mode = r_mode;
        if (r_pick_fast) begin
            n_mode = MODE_FAST;
        end else if (r_pick_medium) begin
            n_mode = MODE_MEDIUM;
        end else if (r_pick_slow) begin
            n_mode = MODE_SLOW;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cw.op == OP_FINISH) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc          <= L_IDLE;
            r_out_valid   <= 1'b0;
            r_mode        <= MODE_FAST;
            r_held_x      <= '0;
            r_held_y      <= '0;
            r_dead_zone   <= DZ_RESET;
            r_speed_limit <= LIM_RESET;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            if (cw.op == OP_FINISH) begin
                r_mode <= n_mode;
            end
            if (held_we && (cw.ax == AX_X)) begin
                r_held_x <= held_val;
            end
            if (held_we && (cw.ax == AX_Y)) begin
                r_held_y <= held_val;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_DEAD_ZONE:   r_dead_zone   <= i_cfg_data[DZ_W-1:0];
                    REG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[LIM_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stick_x     <= i_stick_x;
            r_stick_y     <= i_stick_y;
            r_stick_rot   <= i_stick_rot;
            r_ramp        <= i_ramp_held;
            r_pick_slow   <= i_pick_slow;
            r_pick_medium <= i_pick_medium;
            r_pick_fast   <= i_pick_fast;
        end
        if (cw.op == OP_MUL) begin
            r_prod <= prod_full[PROD_W-1:0];
        end
        if (div_start) begin
            r_dsign <= r_prod[PROD_W-1];
        end
        if (cw.op == OP_ROT_ZERO) begin
            r_rot <= '0;
        end else if (cw.op == OP_ROT_QUO) begin
            r_rot <= q_neg[ROT_W-1:0];
        end
        if (cw.op == OP_FINISH) begin
            r_out_x    <= r_held_x;
            r_out_y    <= r_held_y;
            r_out_rot  <= r_rot;
            r_out_mode <= n_mode;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_vel_x     = r_out_x;
    assign o_vel_y     = r_out_y;
    assign o_vel_rot   = r_out_rot;
    assign o_mode_now  = r_out_mode;

endmodule

[verif/testbench.sv]
// testbench: self-checking bench for joystick_velocity_shaper_top, predicts each beat.
// Depends on jvs_pkg and the shaper RTL; stimulus is directed polls, ramp runs and random traffic.
`timescale 1ns / 1ps

module testbench;
    import jvs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = CFG_IDX_W'(3);

    // mode button sets, ordered {fast, medium, slow}
    localparam logic [2:0] PICK_NONE   = 3'b000;
    localparam logic [2:0] PICK_SLOW   = 3'b001;
    localparam logic [2:0] PICK_MEDIUM = 3'b010;
    localparam logic [2:0] PICK_FAST   = 3'b100;

    localparam int VEL_TOP   = 2**(VEL_W-1) - 1;
    localparam int VEL_FLOOR = -(2**(VEL_W-1));
    localparam int LIM_TOP   = 2**LIM_W - 1;
    localparam int DZ_TOP    = 2**DZ_W - 1;
    localparam int X_NUM     = 3;
    localparam int X_DEN     = 5;
    localparam int ROT_DEN   = 100;

    typedef struct {
        logic [BYTE_W-1:0] sx;
        logic [BYTE_W-1:0] sy;
        logic [BYTE_W-1:0] sr;
        logic              ramp;
        logic [2:0]        picks;
    } t_poll;

    typedef struct {
        logic signed [VEL_W-1:0] vel_x;
        logic signed [VEL_W-1:0] vel_y;
        logic signed [ROT_W-1:0] vel_rot;
        logic [MODE_W-1:0]       mode_now;
    } t_drive_cmd;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [BYTE_W-1:0]       i_stick_x = '0;
    logic [BYTE_W-1:0]       i_stick_y = '0;
    logic [BYTE_W-1:0]       i_stick_rot = '0;
    logic                    i_ramp_held = 1'b0;
    logic                    i_pick_slow = 1'b0;
    logic                    i_pick_medium = 1'b0;
    logic                    i_pick_fast = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [VEL_W-1:0] o_vel_x;
    logic signed [VEL_W-1:0] o_vel_y;
    logic signed [ROT_W-1:0] o_vel_rot;
    logic [MODE_W-1:0]       o_mode_now;

    joystick_velocity_shaper_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_stick_x     (i_stick_x),
        .i_stick_y     (i_stick_y),
        .i_stick_rot   (i_stick_rot),
        .i_ramp_held   (i_ramp_held),
        .i_pick_slow   (i_pick_slow),
        .i_pick_medium (i_pick_medium),
        .i_pick_fast   (i_pick_fast),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_vel_x       (o_vel_x),
        .o_vel_y       (o_vel_y),
        .o_vel_rot     (o_vel_rot),
        .o_mode_now    (o_mode_now)
    );

    always #4 i_clk = ~i_clk;

    // predictor state
    t_mode      cur_mode = MODE_FAST;
    int         held_x = 0;
    int         held_y = 0;
    int         dz_reg = int'(DZ_RESET);
    int         lim_reg = int'(LIM_RESET);

    t_drive_cmd pending_cmds[$];
    int         fail_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         rx_hold = 0;

    function automatic bit is_centered(int off);
        return off <= dz_reg && off >= -dz_reg;
    endfunction

    function automatic bit within_limit(int v);
        return v < lim_reg && v > -lim_reg;
    endfunction

    function automatic int clamp_vel(int v);
        if (v > VEL_TOP) return VEL_TOP;
        if (v < VEL_FLOOR) return VEL_FLOOR;
        return v;
    endfunction

    function automatic int magnitude(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic t_drive_cmd shape_poll(t_poll p);
        int         ox, oy, orot, sum, gain, rotk, accv, stepv, rotv;
        t_drive_cmd c;
        ox   = int'(p.sx) - int'(STICK_CENTER);
        oy   = int'(p.sy) - int'(STICK_CENTER);
        orot = int'(p.sr) - int'(STICK_CENTER);
        sum  = magnitude(ox) + magnitude(oy);
        case (cur_mode)
            MODE_FAST: begin
                gain = 17; rotk = 3; accv = 600;
            end
            MODE_MEDIUM: begin
                gain = 17; rotk = 4; accv = 200;
            end
            default: begin
                gain = 3; rotk = 1; accv = 150;
            end
        endcase

        if (is_centered(oy)) begin
            held_y = 0;
        end else if (!p.ramp) begin
            held_y = gain * oy;
        end else if (within_limit(held_y)) begin
            if (p.sy == STICK_TOP) stepv = accv;
            else if (p.sy == STICK_BOTTOM) stepv = -accv;
            else stepv = (accv * oy) / sum;
            held_y = clamp_vel(held_y + stepv);
        end

        if (is_centered(ox)) begin
            held_x = 0;
        end else if (!p.ramp) begin
            if (p.sx == STICK_TOP || p.sx == STICK_BOTTOM) held_x = -gain * ox;
            else held_x = -((gain * X_NUM * ox) / X_DEN);
        end else if (within_limit(held_x)) begin
            if (p.sx == STICK_TOP) stepv = accv;
            else if (p.sx == STICK_BOTTOM) stepv = -accv;
            else stepv = (accv * ox) / sum;
            held_x = clamp_vel(held_x - stepv);
        end

        rotv = is_centered(orot) ? 0 : -((rotk * orot) / ROT_DEN);

        if (p.picks[2]) cur_mode = MODE_FAST;
        else if (p.picks[1]) cur_mode = MODE_MEDIUM;
        else if (p.picks[0]) cur_mode = MODE_SLOW;

        c.vel_x    = held_x[VEL_W-1:0];
        c.vel_y    = held_y[VEL_W-1:0];
        c.vel_rot  = rotv[ROT_W-1:0];
        c.mode_now = cur_mode;
        return c;
    endfunction

    function automatic t_poll mk(int sx, int sy, int sr, bit ramp, logic [2:0] picks);
        t_poll p;
        p.sx    = sx[BYTE_W-1:0];
        p.sy    = sy[BYTE_W-1:0];
        p.sr    = sr[BYTE_W-1:0];
        p.ramp  = ramp;
        p.picks = picks;
        return p;
    endfunction

    // extremes, center and dead zone edges are favored
    function automatic logic [BYTE_W-1:0] pick_byte();
        int v;
        case ($urandom_range(9))
            0: v = int'(STICK_BOTTOM);
            1: v = int'(STICK_TOP);
            2: v = int'(STICK_CENTER);
            3: v = int'(STICK_CENTER) + dz_reg + int'($urandom_range(1));
            4: v = int'(STICK_CENTER) - dz_reg - int'($urandom_range(1));
            default: v = int'($urandom_range(255));
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[BYTE_W-1:0];
    endfunction

    function automatic t_poll random_poll();
        t_poll p;
        p.sx    = pick_byte();
        p.sy    = pick_byte();
        p.sr    = pick_byte();
        p.ramp  = 1'($urandom_range(1));
        p.picks = ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : PICK_NONE;
        return p;
    endfunction

    task automatic send_poll(t_poll p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_stick_x     <= p.sx;
        i_stick_y     <= p.sy;
        i_stick_rot   <= p.sr;
        i_ramp_held   <= p.ramp;
        i_pick_fast   <= p.picks[2];
        i_pick_medium <= p.picks[1];
        i_pick_slow   <= p.picks[0];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_cmds.push_back(shape_poll(p));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == REG_DEAD_ZONE) dz_reg = int'(data[DZ_W-1:0]);
        else if (idx == REG_SPEED_LIMIT) lim_reg = int'(data[LIM_W-1:0]);
    endtask

    // upper data bits on the dead zone write are junk and must be dropped
    task automatic set_regs(int dz, int lim);
        logic [CFG_DATA_W-1:0] junk;
        wait_drained();
        junk = CFG_DATA_W'($urandom());
        write_reg(REG_DEAD_ZONE, {junk[CFG_DATA_W-1:DZ_W], dz[DZ_W-1:0]});
        write_reg(REG_SPEED_LIMIT, lim[LIM_W-1:0]);
        write_reg(CFG_IDX_W'($urandom_range(REG_NONE_HI, REG_NONE_LO)), ~junk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string what, logic [VEL_W-1:0] want, logic [VEL_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%h actual 0x%h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // result side: check each beat, then pick the next ready
    always @(posedge i_clk) begin
        t_drive_cmd want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_cmds.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none actual x=0x%h y=0x%h",
                             $time, o_vel_x, o_vel_y);
                    fail_count++;
                end else begin
                    want = pending_cmds.pop_front();
                    check_field("vel_x", want.vel_x, o_vel_x);
                    check_field("vel_y", want.vel_y, o_vel_y);
                    check_field("vel_rot", VEL_W'(want.vel_rot), VEL_W'(o_vel_rot));
                    check_field("mode_now", VEL_W'(want.mode_now), VEL_W'(o_mode_now));
                end
            end
            if (rx_hold > 0) begin
                rx_hold = rx_hold - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic test_reset_values();
        send_poll(mk(127, 127, 127, 0, PICK_NONE));
        send_poll(mk(0, 255, 0, 0, PICK_NONE));
        send_poll(mk(255, 0, 255, 0, PICK_NONE));
        send_poll(mk(200, 60, 190, 0, PICK_NONE));
        send_poll(mk(117, 137, 117, 0, PICK_NONE));
        send_poll(mk(116, 138, 138, 0, PICK_NONE));
        send_poll(mk(0, 255, 127, 1, PICK_NONE));
        send_poll(mk(0, 255, 127, 1, PICK_NONE));
        send_poll(mk(90, 170, 127, 1, PICK_NONE));
        send_poll(mk(255, 0, 127, 1, PICK_NONE));
        send_poll(mk(127, 127, 127, 0, PICK_MEDIUM));
        send_poll(mk(60, 200, 30, 1, PICK_NONE));
        send_poll(mk(60, 200, 30, 0, PICK_SLOW));
        send_poll(mk(200, 50, 220, 0, PICK_NONE));
        send_poll(mk(0, 0, 0, 1, PICK_FAST | PICK_MEDIUM | PICK_SLOW));
        send_poll(mk(255, 255, 255, 0, PICK_MEDIUM | PICK_SLOW));
        send_poll(mk(1, 254, 1, 0, PICK_NONE));
        send_poll(mk(127, 127, 127, 0, PICK_FAST | PICK_MEDIUM));
    endtask

    task automatic test_register_extremes();
        // widest dead zone, zero limit: no ramp step ever
        set_regs(DZ_TOP, 0);
        send_poll(mk(0, 255, 0, 1, PICK_NONE));
        send_poll(mk(255, 0, 255, 0, PICK_NONE));
        send_poll(mk(128, 126, 129, 1, PICK_NONE));
        set_regs(0, LIM_TOP);
        send_poll(mk(128, 126, 128, 1, PICK_NONE));
        send_poll(mk(126, 128, 126, 0, PICK_NONE));
    endtask

    // limit at the top of the 15-bit range lets the ramp run into saturation both ways
    task automatic test_saturation();
        set_regs(0, LIM_TOP);
        send_poll(mk(127, 127, 127, 0, PICK_FAST));
        repeat (30) send_poll(mk(STICK_BOTTOM, STICK_TOP, 127, 1, PICK_NONE));
        send_poll(mk(127, 127, 127, 0, PICK_NONE));
        repeat (30) send_poll(mk(STICK_TOP, STICK_BOTTOM, 127, 1, PICK_NONE));
    endtask

    task automatic test_backpressure();
        set_regs(10, 10000);
        rx_hold = 300;
        repeat (20) send_poll(random_poll());
        wait_drained();
    endtask

    // mostly ramp runs with a held stick position, the rest plain polls and noise
    task automatic run_random(int n_items);
        int          sent, run_len, kind, i;
        t_poll       p;
        logic [BYTE_W-1:0] bx, by;
        sent = 0;
        while (sent < n_items) begin
            run_len = $urandom_range(30, 4);
            kind    = $urandom_range(9);
            bx      = pick_byte();
            by      = pick_byte();
            for (i = 0; i < run_len && sent < n_items; i++) begin
                p = random_poll();
                if (kind < 6) begin
                    if ($urandom_range(3) == 0) bx = pick_byte();
                    if ($urandom_range(3) == 0) by = pick_byte();
                    p.ramp = 1'b1;
                    p.sx   = bx;
                    p.sy   = by;
                end else if (kind < 8) begin
                    p.ramp = 1'b0;
                end
                send_poll(p);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic(int s_pct, int r_pct);
        int chunk, dz, lim;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (chunk = 0; chunk < 3; chunk++) begin
            dz  = ($urandom_range(3) == 0) ? $urandom_range(DZ_TOP) : $urandom_range(24);
            lim = ($urandom_range(3) == 0) ? $urandom_range(LIM_TOP) : $urandom_range(12000, 1500);
            set_regs(dz, lim);
            run_random(150);
        end
    endtask

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        send_idle_pct = 19;
        recv_idle_pct = 51;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_register_extremes();
        test_saturation();
        test_backpressure();
        test_random_traffic(19, 51);
        test_random_traffic(51, 19);
        test_random_traffic(0, 0);
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0 && pending_cmds.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/jvs_pkg.sv
rtl/jvs_div.sv
rtl/joystick_velocity_shaper_top.sv
verif/testbench.sv
